FILE: hw/rtl/ipid_pkg.sv
// shared types and constants of the incremental pid controller
`default_nettype none

package ipid_pkg;

    // fixed widths of the configuration registers and state
    localparam int GAIN_W     = 16;
    localparam int BASE_W     = 16;
    localparam int LIM_W      = 32;
    localparam int REM_W      = BASE_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // reset values of the configuration registers
    localparam logic [BASE_W-1:0] BASE_RESET    = BASE_W'(1);
    localparam logic [LIM_W-1:0]  OUT_MIN_RESET = {1'b1, {(LIM_W-1){1'b0}}};
    localparam logic [LIM_W-1:0]  OUT_MAX_RESET = {1'b0, {(LIM_W-1){1'b1}}};

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_PROP     = 3'd0,
        REG_GAIN_INTEGRAL = 3'd1,
        REG_GAIN_DERIV    = 3'd2,
        REG_SCALE_BASE    = 3'd3,
        REG_OUT_MIN       = 3'd4,
        REG_OUT_MAX       = 3'd5
    } t_reg_idx;

    // clamp status reported with each result
    typedef enum logic [1:0] {
        CS_NONE = 2'd0,
        CS_MIN  = 2'd1,
        CS_MAX  = 2'd2
    } t_clamp;

    // multiplier operand selection
    typedef enum logic [1:0] {
        MS_PROP = 2'd0,
        MS_INT  = 2'd1,
        MS_DER  = 2'd2
    } t_mul_sel;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_ACC,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SUM,
        S_FIN
    } t_state;

    // controls from the sequencer to the datapath
    typedef struct packed {
        logic     in_ready;
        logic     cap;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     acc_init;
        logic     acc_add;
        logic     div_start;
        logic     sum_en;
        logic     commit;
    } t_seq_ctl;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic in_valid;
        logic in_clear;
        logic div_done;
        logic slot_free;
    } t_seq_sts;

endpackage

`default_nettype wire

FILE: hw/rtl/ipid_in_if.sv
// error sample channel: valid/ready handshake with the sample and clear bit
`default_nettype none

interface ipid_in_if #(
    parameter int ERR_WIDTH = 16
);
    logic                        valid;
    logic                        ready;
    logic signed [ERR_WIDTH-1:0] err_sample;
    logic                        clear;

    modport source (output valid, output err_sample, output clear, input ready);
    modport sink   (input valid, input err_sample, input clear, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ipid_out_if.sv
// drive result channel: valid/ready handshake with the output and clamp status
`default_nettype none

interface ipid_out_if #(
    parameter int OUT_WIDTH = 32
);
    logic                        valid;
    logic                        ready;
    logic signed [OUT_WIDTH-1:0] drive;
    logic [1:0]                  clamp_state;

    modport source (output valid, output drive, output clamp_state, input ready);
    modport sink   (input valid, input drive, input clamp_state, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ipid_sdiv.sv
// serial signed divider: one quotient bit per cycle, truncation toward zero
`default_nettype none

module ipid_sdiv #(
    parameter int DIVIDEND_W = 35
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic signed [DIVIDEND_W-1:0]      i_dividend,
    input  wire logic [ipid_pkg::BASE_W-1:0]       i_divisor,
    output logic                                   o_done,
    output logic [DIVIDEND_W-1:0]                  o_quot_mag,
    output logic [ipid_pkg::BASE_W-1:0]            o_rem_mag,
    output logic                                   o_neg
);
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);
    localparam int BW    = ipid_pkg::BASE_W;

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_mag;
    logic [BW-1:0]         r_rem;
    logic [BW-1:0]         r_base;
    logic                  r_neg;

    logic [BW:0]           w_trial;
    logic                  w_ge;
    logic [BW:0]           w_diff;

    // trial subtract of the divisor from the shifted partial remainder
    always_comb begin
        w_trial = {r_rem, r_mag[DIVIDEND_W-1]};
        w_diff  = w_trial - {1'b0, r_base};
        w_ge    = (w_trial >= {1'b0, r_base});
    end

    // control: busy flag, step counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: magnitude load, then shift in one quotient bit per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_dividend[DIVIDEND_W-1];
            r_mag  <= i_dividend[DIVIDEND_W-1] ? -i_dividend : i_dividend;
            r_rem  <= '0;
            r_base <= (i_divisor == '0) ? BW'(1) : i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[BW-1:0] : w_trial[BW-1:0];
            r_mag <= {r_mag[DIVIDEND_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quot_mag = r_mag;
    assign o_rem_mag  = r_rem;
    assign o_neg      = r_neg;

endmodule

`default_nettype wire

FILE: hw/rtl/ipid_seq.sv
// sequencer of the shared multiplier, the serial divider and the update step
`default_nettype none

module ipid_seq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ipid_pkg::t_seq_sts i_sts,
    output ipid_pkg::t_seq_ctl      o_ctl
);
    ipid_pkg::t_state r_state;
    ipid_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipid_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ipid_pkg::S_IDLE: begin
                if (i_sts.in_valid) begin
                    n_state = i_sts.in_clear ? ipid_pkg::S_FIN : ipid_pkg::S_MUL0;
                end
            end
            ipid_pkg::S_MUL0:     n_state = ipid_pkg::S_MUL1;
            ipid_pkg::S_MUL1:     n_state = ipid_pkg::S_MUL2;
            ipid_pkg::S_MUL2:     n_state = ipid_pkg::S_ACC;
            ipid_pkg::S_ACC:      n_state = ipid_pkg::S_DIV_GO;
            ipid_pkg::S_DIV_GO:   n_state = ipid_pkg::S_DIV_WAIT;
            ipid_pkg::S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = ipid_pkg::S_SUM;
                end
            end
            ipid_pkg::S_SUM:      n_state = ipid_pkg::S_FIN;
            ipid_pkg::S_FIN: begin
                if (i_sts.slot_free) begin
                    n_state = ipid_pkg::S_IDLE;
                end
            end
            default:              n_state = ipid_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ctl         = '0;
        o_ctl.mul_sel = ipid_pkg::MS_PROP;
        unique case (r_state)
            ipid_pkg::S_IDLE: begin
                o_ctl.in_ready = 1'b1;
                o_ctl.cap      = i_sts.in_valid;
            end
            ipid_pkg::S_MUL0: begin
                o_ctl.mul_en   = 1'b1;
                o_ctl.mul_sel  = ipid_pkg::MS_PROP;
                o_ctl.acc_init = 1'b1;
            end
            ipid_pkg::S_MUL1: begin
                o_ctl.mul_en  = 1'b1;
                o_ctl.mul_sel = ipid_pkg::MS_INT;
                o_ctl.acc_add = 1'b1;
            end
            ipid_pkg::S_MUL2: begin
                o_ctl.mul_en  = 1'b1;
                o_ctl.mul_sel = ipid_pkg::MS_DER;
                o_ctl.acc_add = 1'b1;
            end
            ipid_pkg::S_ACC: begin
                o_ctl.acc_add = 1'b1;
            end
            ipid_pkg::S_DIV_GO: begin
                o_ctl.div_start = 1'b1;
            end
            ipid_pkg::S_DIV_WAIT: begin
            end
            ipid_pkg::S_SUM: begin
                o_ctl.sum_en = 1'b1;
            end
            ipid_pkg::S_FIN: begin
                o_ctl.commit = i_sts.slot_free;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/incremental_pid_with_remainder.sv
// top level of the incremental pid controller with carried division remainder
//
// Usage: error samples enter on i_err_chan (valid/ready), one result per
// transaction leaves on o_drv_chan (valid/ready). Gains, scale base and clamp
// limits are set through the write port i_cfg_we/i_cfg_idx/i_cfg_data while
// the block is idle; a write lands at the clock edge where i_cfg_we is high.
// A step transaction runs three multiplies on one shared 16-bit-gain
// multiplier, then a serial divider that resolves one quotient bit per
// cycle over ERR_WIDTH+19 bits, then an add and a clamp. A clear
// transaction skips the multiplies and the divider and goes straight to
// the clamp state, which writes its zero result into the output register
// once that register is free. The input is ready only between
// transactions, one transaction at a time, so a new sample is taken only
// after the previous one has been committed.
// If the receiver stalls, the finished result waits in the output register;
// a new sample is still taken, and its update waits at the end until the
// output register frees. Synchronous reset clears the controller state and
// restores the configuration defaults (gains 0, base 1, full-range limits).
`default_nettype none

module incremental_pid_with_remainder #(
    parameter int ERR_WIDTH = 16,
    parameter int OUT_WIDTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [ipid_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [ipid_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    ipid_in_if.sink                                  i_err_chan,
    ipid_out_if.source                               o_drv_chan
);
    localparam int GW     = ipid_pkg::GAIN_W;
    localparam int BW     = ipid_pkg::BASE_W;
    localparam int LW     = ipid_pkg::LIM_W;
    localparam int RW     = ipid_pkg::REM_W;
    localparam int DIFF_W = ERR_WIDTH + 2;
    localparam int PROD_W = DIFF_W + GW;
    localparam int ACC_W  = ERR_WIDTH + 19;
    localparam int SUM_W  = ((ACC_W > LW) ? ACC_W : LW) + 1;

    ipid_pkg::t_seq_ctl ctl;
    ipid_pkg::t_seq_sts sts;

    // configuration registers
    logic signed [GW-1:0]        r_gain_prop;
    logic signed [GW-1:0]        r_gain_integral;
    logic signed [GW-1:0]        r_gain_deriv;
    logic [BW-1:0]               r_scale_base;
    logic signed [LW-1:0]        r_out_min;
    logic signed [LW-1:0]        r_out_max;

    // controller state
    logic signed [RW-1:0]        r_carry_rem;
    logic signed [ERR_WIDTH-1:0] r_err_prev;
    logic signed [ERR_WIDTH-1:0] r_err_prev2;
    logic signed [LW-1:0]        r_held;

    // per-transaction working registers
    logic signed [ERR_WIDTH-1:0] r_e;
    logic                        r_clear;
    logic signed [DIFF_W-1:0]    r_d1;
    logic signed [DIFF_W-1:0]    r_d2;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [ACC_W-1:0]     r_acc;
    logic signed [SUM_W-1:0]     r_sum;
    logic signed [RW-1:0]        r_rem_new;

    // output register
    logic                        r_out_valid;
    logic signed [OUT_WIDTH-1:0] r_drive;
    ipid_pkg::t_clamp            r_cs;

    logic signed [GW-1:0]        w_gain;
    logic signed [DIFF_W-1:0]    w_opd;
    logic signed [PROD_W-1:0]    w_prod;
    logic                        w_div_done;
    logic [ACC_W-1:0]            w_qmag;
    logic [BW-1:0]               w_rmag;
    logic                        w_neg;
    logic [SUM_W-1:0]            w_qext;
    logic                        w_slot_free;
    logic signed [LW-1:0]        w_new_held;
    logic signed [RW-1:0]        w_new_rem;
    ipid_pkg::t_clamp            w_new_cs;

    // sequencer
    assign w_slot_free   = !r_out_valid || o_drv_chan.ready;
    assign sts.in_valid  = i_err_chan.valid;
    assign sts.in_clear  = i_err_chan.clear;
    assign sts.div_done  = w_div_done;
    assign sts.slot_free = w_slot_free;

    ipid_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    assign i_err_chan.ready = ctl.in_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_prop     <= '0;
            r_gain_integral <= '0;
            r_gain_deriv    <= '0;
            r_scale_base    <= ipid_pkg::BASE_RESET;
            r_out_min       <= ipid_pkg::OUT_MIN_RESET;
            r_out_max       <= ipid_pkg::OUT_MAX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ipid_pkg::REG_GAIN_PROP:     r_gain_prop     <= i_cfg_data[GW-1:0];
                ipid_pkg::REG_GAIN_INTEGRAL: r_gain_integral <= i_cfg_data[GW-1:0];
                ipid_pkg::REG_GAIN_DERIV:    r_gain_deriv    <= i_cfg_data[GW-1:0];
                ipid_pkg::REG_SCALE_BASE:    r_scale_base    <= i_cfg_data[BW-1:0];
                ipid_pkg::REG_OUT_MIN:       r_out_min       <= i_cfg_data[LW-1:0];
                ipid_pkg::REG_OUT_MAX:       r_out_max       <= i_cfg_data[LW-1:0];
                default: begin
                end
            endcase
        end
    end

    // capture the sample and form first and second differences
    always_ff @(posedge i_clk) begin
        if (ctl.cap) begin
            r_e     <= i_err_chan.err_sample;
            r_clear <= i_err_chan.clear;
            r_d1    <= DIFF_W'(i_err_chan.err_sample) - DIFF_W'(r_err_prev);
            r_d2    <= DIFF_W'(i_err_chan.err_sample) - (DIFF_W'(r_err_prev) <<< 1)
                       + DIFF_W'(r_err_prev2);
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (ctl.mul_sel)
            ipid_pkg::MS_PROP: begin
                w_gain = r_gain_prop;
                w_opd  = r_d1;
            end
            ipid_pkg::MS_INT: begin
                w_gain = r_gain_integral;
                w_opd  = DIFF_W'(r_e);
            end
            ipid_pkg::MS_DER: begin
                w_gain = r_gain_deriv;
                w_opd  = r_d2;
            end
            default: begin
                w_gain = '0;
                w_opd  = '0;
            end
        endcase
        w_prod = PROD_W'(w_gain) * PROD_W'(w_opd);
    end

    // registered product and accumulator seeded with the carried remainder
    always_ff @(posedge i_clk) begin
        if (ctl.mul_en) begin
            r_prod <= w_prod;
        end
        if (ctl.acc_init) begin
            r_acc <= ACC_W'(r_carry_rem);
        end else if (ctl.acc_add) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // serial divider by the scale base
    ipid_sdiv #(
        .DIVIDEND_W (ACC_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ctl.div_start),
        .i_dividend (r_acc),
        .i_divisor  (r_scale_base),
        .o_done     (w_div_done),
        .o_quot_mag (w_qmag),
        .o_rem_mag  (w_rmag),
        .o_neg      (w_neg)
    );

    // add the signed quotient to the held output, sign the remainder
    assign w_qext = SUM_W'(w_qmag);

    always_ff @(posedge i_clk) begin
        if (ctl.sum_en) begin
            r_sum     <= SUM_W'(r_held) + (w_neg ? ~w_qext : w_qext) + SUM_W'(w_neg);
            r_rem_new <= w_neg ? -RW'(w_rmag) : RW'(w_rmag);
        end
    end

    // clamp against the limits, lower limit tested first; a clear gives zero
    always_comb begin
        if (r_clear) begin
            w_new_held = '0;
            w_new_rem  = '0;
            w_new_cs   = ipid_pkg::CS_NONE;
        end else if (r_sum < SUM_W'(r_out_min)) begin
            w_new_held = r_out_min;
            w_new_rem  = '0;
            w_new_cs   = ipid_pkg::CS_MIN;
        end else if (r_sum > SUM_W'(r_out_max)) begin
            w_new_held = r_out_max;
            w_new_rem  = '0;
            w_new_cs   = ipid_pkg::CS_MAX;
        end else begin
            w_new_held = r_sum[LW-1:0];
            w_new_rem  = r_rem_new;
            w_new_cs   = ipid_pkg::CS_NONE;
        end
    end

    // state update on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry_rem <= '0;
            r_err_prev  <= '0;
            r_err_prev2 <= '0;
            r_held      <= '0;
        end else if (ctl.commit) begin
            r_carry_rem <= w_new_rem;
            r_held      <= w_new_held;
            r_err_prev  <= r_clear ? '0 : r_e;
            r_err_prev2 <= r_clear ? '0 : r_err_prev;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.commit) begin
            r_out_valid <= 1'b1;
        end else if (o_drv_chan.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.commit) begin
            r_drive <= OUT_WIDTH'(w_new_held);
            r_cs    <= w_new_cs;
        end
    end

    assign o_drv_chan.valid       = r_out_valid;
    assign o_drv_chan.drive       = r_drive;
    assign o_drv_chan.clamp_state = r_cs;

    // no second transaction is taken right after one is accepted
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_err_chan.valid && i_err_chan.ready) |=> !i_err_chan.ready)
        else $error("input ready right after an accepted transaction");

    // a step with ordered limits leaves the held output inside them
    a_held_in_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.commit && !r_clear && (r_out_min <= r_out_max))
        |=> (r_held >= r_out_min) && (r_held <= r_out_max))
        else $error("held output outside clamp limits");

    // a clamped result leaves no carried remainder
    a_clamp_clears_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_drv_chan.valid && (o_drv_chan.clamp_state != ipid_pkg::CS_NONE))
        |-> (r_carry_rem == '0))
        else $error("remainder kept after clamp");

    // a clear zeroes the controller state
    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.commit && r_clear)
        |=> (r_held == '0) && (r_err_prev == '0) && (r_err_prev2 == '0))
        else $error("state not zero after clear");

endmodule

`default_nettype wire
